>>> rtl/cpm_pkg.sv
// Package for the coalescing priority mailbox: transfer structs, codes and the sequencer states.
// Used by coalescing_priority_mailbox_unit; it depends on nothing.
package cpm_pkg;

	typedef enum logic [1:0] {
		FUNC_PUBLISH = 2'd0,
		FUNC_DRAIN   = 2'd1,
		FUNC_CLEAR   = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_REJECTED = 3'd0,
		KIND_ACCEPTED = 3'd1,
		KIND_DRAINED  = 3'd2,
		KIND_EMPTY    = 3'd3,
		KIND_CLEARED  = 3'd4
	} kind_t;

	localparam int EntW = 32 + 1 + 8 + 32 + 16 + 32 + 32 + 32;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] source_id;
		logic        src_only;
		logic [7:0]  lane;
		logic [31:0] pitch;
		logic [15:0] volume;
		logic [31:0] lifetime;
		logic [31:0] emit_tick;
		logic [31:0] payload;
	} cmd_t;

	typedef struct packed {
		logic [31:0] source_id;
		logic        src_only;
		logic [7:0]  lane;
		logic [31:0] pitch;
		logic [15:0] volume;
		logic [31:0] lifetime;
		logic [31:0] tick;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] out_source_id;
		logic        out_src_only;
		logic [7:0]  out_lane;
		logic [31:0] out_pitch;
		logic [15:0] out_volume;
		logic [31:0] out_lifetime;
		logic [31:0] out_tick;
		logic [31:0] out_payload;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRUNE_RD,
		ST_PRUNE,
		ST_MATCH_RD,
		ST_MATCH,
		ST_VICT_RD,
		ST_VICT,
		ST_SHIFT_RD,
		ST_SHIFT,
		ST_WRITE,
		ST_DRAIN_RD,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic [1:0] prio_of(input logic so, input logic [31:0] pit,
		input logic [15:0] vol);
		if (so) begin
			return 2'd1;
		end else if (pit == 32'd0 || vol == 16'd0) begin
			return 2'd2;
		end
		return 2'd0;
	endfunction

endpackage

>>> rtl/coalescing_priority_mailbox_unit.sv
// Top level of the coalescing priority mailbox: sequencer, entry store and result register.
// Depends on cpm_pkg and cpm_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------
//  command  | start, busy        | cmd (cpm_pkg::cmd_t)
//  result   | result_valid       | result (cpm_pkg::result_t)
//
// A publish makes passes over the store: one pass prunes expired entries, one
// searches for a key match, and on a full store one pass may pick a victim and,
// if one is found, one closes the gap. All passes share one RAM read port with
// a registered read.
// A drain gives one result per stored entry, or one empty result; clear and unused codes give one.
// Reset clears the sequencer and the entry count; the store itself is not cleared.
// The receiver cannot stall: each result shows for one cycle with result_valid.
module coalescing_priority_mailbox_unit #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cpm_pkg::cmd_t    cmd,
	output logic             result_valid,
	output cpm_pkg::result_t result
);
	import cpm_pkg::*;

	localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CntW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [CntW-1:0] count_q, count_d;
	// Read pointer and write pointer for the passes over the store.
	logic [CntW-1:0] rd_q, rd_d, wr_q, wr_d;
	logic [IdxW-1:0] victim_q, victim_d;
	logic [1:0]      vprio_q, vprio_d;
	logic            found_q, found_d;
	logic            res_valid_q;
	result_t         res_q, res_d;
	logic            res_load;

	logic            we;
	logic [IdxW-1:0] waddr, raddr;
	entry_t          wdata, rdata, new_ent;

	cpm_ram #(.Width(EntW), .Depth(CAPACITY)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign new_ent = '{source_id: cmd_q.source_id, src_only: cmd_q.src_only,
		lane: cmd_q.lane, pitch: cmd_q.pitch, volume: cmd_q.volume,
		lifetime: cmd_q.lifetime, tick: cmd_q.emit_tick, payload: cmd_q.payload};

	// Shared compare unit: one entry against the command at a time.
	logic [31:0] life_eff, age;
	logic        alive, key_hit;
	logic [1:0]  ent_prio, inc_prio;
	assign life_eff = (rdata.lifetime == 32'd0) ? 32'd1 : rdata.lifetime;
	assign age      = cmd_q.emit_tick - rdata.tick;
	assign alive    = (age <= life_eff);
	assign key_hit  = (rdata.source_id == cmd_q.source_id) &&
		(rdata.src_only == cmd_q.src_only) &&
		(rdata.src_only || rdata.lane == cmd_q.lane);
	assign ent_prio = prio_of(rdata.src_only, rdata.pitch, rdata.volume);
	assign inc_prio = prio_of(cmd_q.src_only, cmd_q.pitch, cmd_q.volume);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			res_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
		rd_q     <= rd_d;
		wr_q     <= wr_d;
		victim_q <= victim_d;
		vprio_q  <= vprio_d;
		found_q  <= found_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	function automatic result_t simple(input kind_t k);
		result_t r;
		r      = '0;
		r.kind = k;
		r.last = 1'b1;
		return r;
	endfunction

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		rd_d     = rd_q;
		wr_d     = wr_q;
		victim_d = victim_q;
		vprio_d  = vprio_q;
		found_d  = found_q;
		res_load = 1'b0;
		res_d    = simple(KIND_REJECTED);
		we       = 1'b0;
		waddr    = wr_q[IdxW-1:0];
		wdata    = rdata;
		raddr    = rd_q[IdxW-1:0];
		case (state_q)
			ST_IDLE: begin
				rd_d = '0;
				wr_d = '0;
				if (start) begin
					case (func_t'(cmd.func))
						FUNC_PUBLISH: state_d = ST_PRUNE_RD;
						FUNC_DRAIN: begin
							if (count_q == '0) begin
								res_load = 1'b1;
								res_d    = simple(KIND_EMPTY);
								state_d  = ST_DONE;
							end else begin
								state_d = ST_DRAIN_RD;
							end
						end
						FUNC_CLEAR: begin
							count_d  = '0;
							res_load = 1'b1;
							res_d    = simple(KIND_CLEARED);
							state_d  = ST_DONE;
						end
						default: begin
							res_load = 1'b1;
							state_d  = ST_DONE;
						end
					endcase
				end
			end
			ST_PRUNE_RD: begin
				if (rd_q == count_q) begin
					count_d = wr_q;
					rd_d    = '0;
					state_d = ST_MATCH_RD;
				end else begin
					state_d = ST_PRUNE;
				end
			end
			ST_PRUNE: begin
				// Survivors slide down over the expired ones, order kept.
				if (alive) begin
					we   = 1'b1;
					wr_d = wr_q + 1'b1;
				end
				rd_d    = rd_q + 1'b1;
				raddr   = rd_d[IdxW-1:0];
				state_d = ST_PRUNE_RD;
			end
			ST_MATCH_RD: begin
				if (rd_q == count_q) begin
					if (count_q == CntW'(CAPACITY)) begin
						rd_d     = '0;
						found_d  = 1'b0;
						vprio_d  = inc_prio;
						state_d  = (inc_prio == 2'd0) ? ST_DONE : ST_VICT_RD;
						res_load = (inc_prio == 2'd0);
					end else begin
						state_d = ST_WRITE;
					end
				end else begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (key_hit) begin
					we       = 1'b1;
					waddr    = rd_q[IdxW-1:0];
					wdata    = new_ent;
					res_load = 1'b1;
					res_d    = simple(KIND_ACCEPTED);
					state_d  = ST_DONE;
				end else begin
					rd_d    = rd_q + 1'b1;
					raddr   = rd_d[IdxW-1:0];
					state_d = ST_MATCH_RD;
				end
			end
			ST_VICT_RD: begin
				if (rd_q == count_q) begin
					if (!found_q) begin
						res_load = 1'b1;
						state_d  = ST_DONE;
					end else begin
						wr_d    = CntW'(victim_q);
						rd_d    = CntW'(victim_q) + 1'b1;
						raddr   = rd_d[IdxW-1:0];
						state_d = ST_SHIFT_RD;
					end
				end else begin
					state_d = ST_VICT;
				end
			end
			ST_VICT: begin
				if (ent_prio < vprio_q || (ent_prio == vprio_q && ent_prio < inc_prio)) begin
					victim_d = rd_q[IdxW-1:0];
					vprio_d  = ent_prio;
					found_d  = 1'b1;
				end
				rd_d    = rd_q + 1'b1;
				raddr   = rd_d[IdxW-1:0];
				state_d = ST_VICT_RD;
			end
			ST_SHIFT_RD: begin
				if (rd_q == count_q) begin
					count_d = count_q - 1'b1;
					state_d = ST_WRITE;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				we      = 1'b1;
				wr_d    = wr_q + 1'b1;
				rd_d    = rd_q + 1'b1;
				raddr   = rd_d[IdxW-1:0];
				state_d = ST_SHIFT_RD;
			end
			ST_WRITE: begin
				we       = 1'b1;
				waddr    = count_q[IdxW-1:0];
				wdata    = new_ent;
				count_d  = count_q + 1'b1;
				res_load = 1'b1;
				res_d    = simple(KIND_ACCEPTED);
				state_d  = ST_DONE;
			end
			ST_DRAIN_RD: begin
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				res_load                = 1'b1;
				res_d.kind              = KIND_DRAINED;
				res_d.out_source_id     = rdata.source_id;
				res_d.out_src_only      = rdata.src_only;
				res_d.out_lane          = rdata.lane;
				res_d.out_pitch         = rdata.pitch;
				res_d.out_volume        = rdata.volume;
				res_d.out_lifetime      = rdata.lifetime;
				res_d.out_tick          = rdata.tick;
				res_d.out_payload       = rdata.payload;
				rd_d                    = rd_q + 1'b1;
				raddr                   = rd_d[IdxW-1:0];
				res_d.last              = (rd_d == count_q);
				if (rd_d == count_q) begin
					count_d = '0;
					state_d = ST_DONE;
				end else begin
					state_d = ST_DRAIN_RD;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("entry count above capacity");
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_d.last) |=> state_q == ST_DONE)
		else $error("sequencer did not finish after the last result");
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !start) |=> !result_valid)
		else $error("result without a command");
endmodule

>>> rtl/cpm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; the mailbox uses one instance for its entry store.
module cpm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                            wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                            rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
